// ===== sv/imu_bc_pkg.sv =====
// Shared constants and codes for the IMU bias calibrator.
package imu_bc_pkg;

    // Field and accumulator widths
    localparam int SAMPLE_WIDTH      = 16;
    localparam int SUM_WIDTH         = 32;
    localparam int NUM_AXES          = 6;
    localparam int COUNT_WIDTH_DEF   = 16;

    // Configuration register indexes
    localparam logic REG_CAL_COUNT   = 1'b0;
    localparam logic REG_ACCEL_RANGE = 1'b1;

    // Configuration reset values
    localparam logic [15:0] CAL_COUNT_RST   = 16'd100;
    localparam logic [1:0]  ACCEL_RANGE_RST = 2'd0;

    // Accelerometer full scale codes
    localparam logic [1:0] RANGE_2G  = 2'd0;
    localparam logic [1:0] RANGE_4G  = 2'd1;

    // One g in LSB for the ranges that get gravity removed
    localparam logic [SAMPLE_WIDTH-1:0] ONE_G_2G = 16'd16384;
    localparam logic [SAMPLE_WIDTH-1:0] ONE_G_4G = 16'd8192;

    // Result kinds
    localparam logic [1:0] KIND_RAW       = 2'd0;
    localparam logic [1:0] KIND_CORRECTED = 2'd1;
    localparam logic [1:0] KIND_OFFSETS   = 2'd2;

    // Axis position of Z accel in the axis order ax, ay, az, gx, gy, gz
    localparam logic [2:0] AXIS_ACCEL_Z = 3'd2;
    localparam logic [2:0] AXIS_LAST    = 3'd5;

endpackage

// ===== sv/imu_bc_div.sv =====
// Iterative signed divider: 32-bit sum by unsigned count, one quotient bit a cycle.
module imu_bc_div #(
    parameter int COUNT_WIDTH = imu_bc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [imu_bc_pkg::SUM_WIDTH-1:0]      i_dividend,
    input  logic [COUNT_WIDTH-1:0]                i_divisor,
    output logic                                  o_done,
    output logic [imu_bc_pkg::SAMPLE_WIDTH-1:0]   o_quot
);
    localparam int SW = imu_bc_pkg::SUM_WIDTH;
    localparam int CW = $clog2(SW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_quot;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] r_div;
    logic          r_neg;

    logic [COUNT_WIDTH:0]   w_rem_sh;
    logic                   w_fit;
    logic [COUNT_WIDTH:0]   w_rem_sub;
    logic [SW-1:0]          w_mag;

    // Restoring step: shift in next dividend bit, subtract when it fits
    always_comb begin
        w_rem_sh  = {r_rem, r_quot[SW-1]};
        w_fit     = (w_rem_sh >= {1'b0, r_div});
        w_rem_sub = w_rem_sh - {1'b0, r_div};
        w_mag     = i_dividend[SW-1] ? (~i_dividend + 1'b1) : i_dividend;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(SW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= w_mag;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_neg  <= i_dividend[SW-1];
        end else if (r_busy) begin
            r_quot <= {r_quot[SW-2:0], w_fit};
            r_rem  <= w_fit ? w_rem_sub[COUNT_WIDTH-1:0] : w_rem_sh[COUNT_WIDTH-1:0];
        end
    end

    // Truncation toward zero: negate the magnitude quotient, keep 16 bits
    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_quot[imu_bc_pkg::SAMPLE_WIDTH-1:0] + 1'b1)
                          : r_quot[imu_bc_pkg::SAMPLE_WIDTH-1:0];

endmodule

// ===== sv/imu_bias_calibrator.sv =====
// Top level: sample correction, calibration sums and offset sequencer.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall    | opcode, read_ok, six axes, temp
//  out     | output    | o_out_valid / i_out_stall  | result_kind, six axes, temp
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A measurement word or a calibration word that does not complete a run does
// not hold the input. For the word that completes a run, the shared divider
// works through the six axes in turn, then the report is loaded.
// Reset is synchronous and active low; it clears sums, count and offsets and
// returns config to its reset values. The input stalls while offsets are
// computed, and whenever the output register holds a word that is itself stalled.
module imu_bias_calibrator #(
    parameter int COUNT_WIDTH = imu_bc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic        i_read_ok,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_temperature,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic signed [15:0] o_accel_x_out,
    output logic signed [15:0] o_accel_y_out,
    output logic signed [15:0] o_accel_z_out,
    output logic signed [15:0] o_temperature_out,
    output logic signed [15:0] o_gyro_x_out,
    output logic signed [15:0] o_gyro_y_out,
    output logic signed [15:0] o_gyro_z_out,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int SMW = imu_bc_pkg::SAMPLE_WIDTH;
    localparam int SUW = imu_bc_pkg::SUM_WIDTH;
    localparam int NA  = imu_bc_pkg::NUM_AXES;

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]             r_state;
    logic [2:0]             r_axis;
    logic [15:0]            r_cal_count;
    logic [1:0]             r_accel_range;
    logic [SUW-1:0]         r_sum [NA];
    logic [COUNT_WIDTH-1:0] r_taken;
    logic [SMW-1:0]         r_offset [NA];
    logic                   r_offsets_valid;
    logic [COUNT_WIDTH-1:0] r_divisor;

    logic                   r_out_valid;
    logic [1:0]             r_kind;
    logic [SMW-1:0]         r_out_axis [NA];
    logic [SMW-1:0]         r_out_temp;

    logic                   w_accept;
    logic                   w_out_free;
    logic [SMW-1:0]         w_raw [NA];
    logic [SMW-1:0]         w_temp;
    logic [SUW-1:0]         w_sum_nx [NA];
    logic [COUNT_WIDTH-1:0] w_taken_nx;
    logic [COUNT_WIDTH-1:0] w_cnt;
    logic                   w_complete;
    logic                   w_div_done;
    logic [SMW-1:0]         w_quot;
    logic [SMW-1:0]         w_offset_nx;

    // Handshakes
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Failed read zeroes every sample value
    always_comb begin
        w_raw[0] = i_read_ok ? i_accel_x : '0;
        w_raw[1] = i_read_ok ? i_accel_y : '0;
        w_raw[2] = i_read_ok ? i_accel_z : '0;
        w_raw[3] = i_read_ok ? i_gyro_x  : '0;
        w_raw[4] = i_read_ok ? i_gyro_y  : '0;
        w_raw[5] = i_read_ok ? i_gyro_z  : '0;
        w_temp   = i_read_ok ? i_temperature : '0;
    end

    // Accumulate and test for end of run; a zero count acts as one
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            w_sum_nx[i] = r_sum[i] + {{(SUW-SMW){w_raw[i][SMW-1]}}, w_raw[i]};
        end
        w_taken_nx = r_taken + 1'b1;
        w_cnt      = (r_cal_count[COUNT_WIDTH-1:0] == '0) ? COUNT_WIDTH'(1)
                                                          : r_cal_count[COUNT_WIDTH-1:0];
        w_complete = (w_taken_nx == '0) || (w_taken_nx >= w_cnt);
    end

    // Gravity removal on Z accel
    always_comb begin
        w_offset_nx = w_quot;
        if (r_axis == imu_bc_pkg::AXIS_ACCEL_Z) begin
            case (r_accel_range)
                imu_bc_pkg::RANGE_2G: w_offset_nx = w_quot - imu_bc_pkg::ONE_G_2G;
                imu_bc_pkg::RANGE_4G: w_offset_nx = w_quot - imu_bc_pkg::ONE_G_4G;
                default:              w_offset_nx = w_quot;
            endcase
        end
    end

    // Shared divider
    imu_bc_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (r_sum[r_axis]),
        .i_divisor  (r_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_count   <= imu_bc_pkg::CAL_COUNT_RST;
            r_accel_range <= imu_bc_pkg::ACCEL_RANGE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                imu_bc_pkg::REG_CAL_COUNT:   r_cal_count   <= i_cfg_data;
                imu_bc_pkg::REG_ACCEL_RANGE: r_accel_range <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, sums and offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_axis          <= '0;
            r_taken         <= '0;
            r_offsets_valid <= 1'b0;
            r_divisor       <= '0;
            for (int i = 0; i < NA; i++) begin
                r_sum[i]    <= '0;
                r_offset[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_opcode) begin
                        for (int i = 0; i < NA; i++) r_sum[i] <= w_sum_nx[i];
                        if (w_complete) begin
                            r_taken   <= '0;
                            r_divisor <= w_cnt;
                            r_axis    <= '0;
                            r_state   <= S_START;
                        end else begin
                            r_taken <= w_taken_nx;
                        end
                    end
                end
                S_START: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_div_done) begin
                        r_offset[r_axis] <= w_offset_nx;
                        r_sum[r_axis]    <= '0;
                        if (r_axis == imu_bc_pkg::AXIS_LAST) begin
                            r_offsets_valid <= 1'b1;
                            r_state         <= S_OUT;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_START;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && !i_opcode) || (r_state == S_OUT && w_out_free)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word: corrected or raw sample, or offsets report
    always_ff @(posedge i_clk) begin
        if (w_accept && !i_opcode) begin
            r_kind     <= r_offsets_valid ? imu_bc_pkg::KIND_CORRECTED : imu_bc_pkg::KIND_RAW;
            r_out_temp <= w_temp;
            for (int i = 0; i < NA; i++) begin
                r_out_axis[i] <= r_offsets_valid ? (w_raw[i] - r_offset[i]) : w_raw[i];
            end
        end else if (r_state == S_OUT && w_out_free) begin
            r_kind     <= imu_bc_pkg::KIND_OFFSETS;
            r_out_temp <= '0;
            for (int i = 0; i < NA; i++) r_out_axis[i] <= r_offset[i];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_kind;
    assign o_accel_x_out     = r_out_axis[0];
    assign o_accel_y_out     = r_out_axis[1];
    assign o_accel_z_out     = r_out_axis[2];
    assign o_temperature_out = r_out_temp;
    assign o_gyro_x_out      = r_out_axis[3];
    assign o_gyro_y_out      = r_out_axis[4];
    assign o_gyro_z_out      = r_out_axis[5];

endmodule
